>>> rtl/harmonic_spectrum_analyzer_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef HARMONIC_SPECTRUM_ANALYZER_ASSERT_SVH
`define HARMONIC_SPECTRUM_ANALYZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HSA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HSA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hsa_pkg.sv
`timescale 1ns / 1ps
package hsa_pkg;

	// Defaults for the top-level parameters
	localparam int WINDOW_LEN_DEF = 128;
	localparam int HARMONICS_DEF  = 32;
	localparam int CHANNELS_DEF   = 3;

	// Field widths
	localparam int CH_W     = 2;
	localparam int SAMPLE_W = 24;
	localparam int HARM_W   = 6;
	localparam int MAG_W    = 32;
	localparam int RATIO_W  = 24;
	localparam int TW_W     = 30;

	localparam logic [63:0] TWO_PI_Q32 = 64'h6_487E_D511;
	localparam logic [RATIO_W-1:0] RATIO_MAX = 24'hFF_FFFF;

	// One finished window handed from front to back
	typedef struct packed {
		logic            bank;
		logic [CH_W-1:0] ch;
	} job_t;

	// Back-end control returned to the front
	typedef struct packed {
		logic pop;
		logic free_bank;
		logic bank;
	} back_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_ROUND,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_ENERGY,
		ST_SQRT,
		ST_STORE,
		ST_TOTAL,
		ST_EMIT_START,
		ST_RD_MAG,
		ST_LOAD_DIV,
		ST_DIV,
		ST_OUT
	} back_state_t;

	// Twiddle value (cos or sin of 2*pi*m/2^lg, Q28) by Taylor series, for table build
	function automatic logic signed [TW_W-1:0] twiddle(input int m, input int lg,
		input logic want_sin);
		logic [63:0] mp;
		logic [63:0] q32;
		logic [63:0] theta;
		logic [63:0] term;
		logic signed [63:0] c;
		logic signed [63:0] s;
		int nlen;
		nlen = 1 << lg;
		mp = (2 * m <= nlen) ? 64'(m) : 64'(nlen - m);
		q32 = (TWO_PI_Q32 * mp + (64'(nlen) >> 1)) >> lg;
		theta = (q32 + 64'd8) >> 4;
		term = 64'd1 << 28;
		c = $signed(term);
		s = 64'sd0;
		for (int n = 1; n < 40; n++) begin
			if (term != 64'd0) begin
				term = ((term * theta + (64'd1 << 27)) >> 28) / 64'(n);
				case (2'(n))
					2'd0: c = c + $signed(term);
					2'd1: s = s + $signed(term);
					2'd2: c = c - $signed(term);
					default: s = s - $signed(term);
				endcase
			end
		end
		if (2 * m > nlen) s = -s;
		return want_sin ? TW_W'(s) : TW_W'(c);
	endfunction

endpackage

>>> rtl/hsa_ram.sv
`timescale 1ns / 1ps
module hsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/hsa_front.sv
`timescale 1ns / 1ps
module hsa_front #(
	parameter int WINDOW_LEN = 128,
	parameter int CHANNELS   = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [hsa_pkg::CH_W-1:0]          channel,
	input  logic signed [hsa_pkg::SAMPLE_W-1:0] sample,
	output logic                              win_we,
	output logic [$clog2(WINDOW_LEN):0]       win_waddr,
	output logic [hsa_pkg::SAMPLE_W-1:0]      win_wdata,
	output logic                              job_valid,
	output hsa_pkg::job_t                     job,
	input  hsa_pkg::back_ctl_t                ctl
);
	import hsa_pkg::*;

	localparam int LOGN = $clog2(WINDOW_LEN);

	logic [LOGN-1:0] fill_q;
	logic            wr_bank_q;
	logic [1:0]      busy_q;
	logic [CH_W-1:0] ch_q;
	logic            first_zero_q;
	job_t            queue_q [2];
	logic            q_wp_q;
	logic            q_rp_q;
	logic [1:0]      q_cnt_q;

	logic take;
	logic last_smp;
	logic first_zero_now;
	logic push;
	logic [CH_W-1:0] ch_now;

	// Classify the beat: ignored channel, window fill, window close
	assign in_ready       = !busy_q[wr_bank_q];
	assign take           = in_valid && in_ready && (int'(channel) < CHANNELS);
	assign last_smp       = (fill_q == LOGN'(WINDOW_LEN - 1));
	assign first_zero_now = (fill_q == '0) ? (sample == '0) : first_zero_q;
	assign ch_now         = (fill_q == '0) ? channel : ch_q;
	assign push           = take && last_smp && !first_zero_now;

	assign win_we    = take;
	assign win_waddr = {wr_bank_q, fill_q};
	assign win_wdata = sample;

	assign job_valid = (q_cnt_q != 2'd0);
	assign job       = queue_q[q_rp_q];

	// Fill state and bank ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			wr_bank_q    <= 1'b0;
			busy_q       <= 2'b00;
			ch_q         <= '0;
			first_zero_q <= 1'b0;
		end else begin
			if (take) begin
				if (fill_q == '0) begin
					ch_q         <= channel;
					first_zero_q <= (sample == '0);
				end
				fill_q <= last_smp ? '0 : fill_q + 1'b1;
				if (push) wr_bank_q <= !wr_bank_q;
			end
			for (int b = 0; b < 2; b++) begin
				if (push && (wr_bank_q == 1'(b))) busy_q[b] <= 1'b1;
				else if (ctl.free_bank && (ctl.bank == 1'(b))) busy_q[b] <= 1'b0;
			end
		end
	end

	// Two-entry job queue toward the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wp_q  <= 1'b0;
			q_rp_q  <= 1'b0;
			q_cnt_q <= 2'd0;
		end else begin
			if (push) q_wp_q <= !q_wp_q;
			if (ctl.pop) q_rp_q <= !q_rp_q;
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, ctl.pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[q_wp_q].bank <= wr_bank_q;
			queue_q[q_wp_q].ch   <= ch_now;
		end
	end

endmodule

>>> rtl/hsa_back.sv
`timescale 1ns / 1ps
module hsa_back #(
	parameter int WINDOW_LEN = 128,
	parameter int HARMONICS  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  hsa_pkg::job_t                   job,
	output hsa_pkg::back_ctl_t              ctl,
	output logic [$clog2(WINDOW_LEN):0]     win_raddr,
	input  logic [hsa_pkg::SAMPLE_W-1:0]    win_rdata,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hsa_pkg::CH_W-1:0]        loop_id,
	output logic [hsa_pkg::HARM_W-1:0]      harmonic,
	output logic [hsa_pkg::MAG_W-1:0]       rms_magnitude,
	output logic [hsa_pkg::RATIO_W-1:0]     content_ratio,
	output logic                            fundamental_zero,
	output logic                            last
);
	import hsa_pkg::*;

	localparam int LOGN  = $clog2(WINDOW_LEN);
	localparam int CNT_W = LOGN + 1;
	localparam int MAW   = $clog2(HARMONICS);
	localparam int SH    = LOGN + 20;
	localparam logic [63:0] HALF = 64'd1 << (SH - 1);
	localparam int PROD_W = SAMPLE_W + TW_W;
	localparam int DIV_N  = MAG_W + 16;

	// Twiddle tables, fixed at elaboration
	logic signed [TW_W-1:0] cos_tab [WINDOW_LEN];
	logic signed [TW_W-1:0] sin_tab [WINDOW_LEN];
	for (genvar m = 0; m < WINDOW_LEN; m++) begin : g_tw
		assign cos_tab[m] = twiddle(m, LOGN, 1'b0);
		assign sin_tab[m] = twiddle(m, LOGN, 1'b1);
	end

	back_state_t state_q, state_nxt;

	logic                     bank_q;
	logic [CH_W-1:0]          ch_q;
	logic [HARM_W-1:0]        k_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [LOGN-1:0]          idx_q;
	logic signed [TW_W-1:0]   tw_c_s1, tw_s_s1;
	logic                     v_s1, v_s2;
	logic signed [PROD_W-1:0] prod_c_s2, prod_s_s2;
	logic signed [63:0]       re_q, im_q;
	logic [MAG_W-1:0]         vr_q, vi_q;
	logic [63:0]              sq_re_q, sq_im_q;
	logic [63:0]              e_q, total_q;
	logic [63:0]              sv_q, sr_q, sbit_q;
	logic                     stot_q;
	logic [MAG_W-1:0]         tot_rms_q, rms1_q, mag_q;
	logic [DIV_N-1:0]         num_q, quo_q;
	logic [MAG_W:0]           rem_q;
	logic [MAG_W-1:0]         den_q;
	logic [5:0]               dcnt_q;
	logic                     out_valid_q;

	logic              issue;
	logic              last_k;
	logic              out_load;
	logic [MAG_W-1:0]  den_w;
	logic [MAG_W-1:0]  mag_rdata;
	logic [63:0]       e_w;
	logic [63:0]       sr_bit;
	logic [MAG_W:0]    rem_sh;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// |x| / (N * 2^20), rounded half away from zero, saturated to 32 bits
	function automatic logic [MAG_W-1:0] round_q8(input logic signed [63:0] x);
		logic [63:0] mag;
		logic [63:0] q;
		mag = x[63] ? 64'(-x) : 64'(x);
		q = (mag + HALF) >> SH;
		return (q > 64'hFFFF_FFFF) ? '1 : q[MAG_W-1:0];
	endfunction

	assign issue  = (state_q == ST_MAC) && !cnt_q[LOGN];
	assign last_k = (k_q == HARM_W'(HARMONICS - 1));
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign den_w  = (k_q == '0) ? tot_rms_q : rms1_q;
	assign win_raddr = {bank_q, cnt_q[LOGN-1:0]};

	// Energy of the bin, doubled for AC bins
	always_comb begin
		e_w = sat_add(sq_re_q, sq_im_q);
		if (k_q != '0) e_w = sat_add(e_w, e_w);
	end

	assign sr_bit = sr_q + sbit_q;
	assign rem_sh = {rem_q[MAG_W-1:0], num_q[DIV_N-1]};

	// Magnitude store, one entry per harmonic
	hsa_ram #(.WIDTH(MAG_W), .DEPTH(HARMONICS)) u_mag_ram (
		.clk  (clk),
		.we   (state_q == ST_STORE),
		.waddr(k_q[MAW-1:0]),
		.wdata(sr_q[MAG_W-1:0]),
		.raddr(k_q[MAW-1:0]),
		.rdata(mag_rdata)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt     = state_q;
		ctl.pop       = 1'b0;
		ctl.free_bank = 1'b0;
		ctl.bank      = bank_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					ctl.pop   = 1'b1;
					state_nxt = ST_MAC;
				end
			end
			ST_MAC: if (cnt_q == CNT_W'(WINDOW_LEN + 1)) state_nxt = ST_ROUND;
			ST_ROUND:  state_nxt = ST_SQ_RE;
			ST_SQ_RE:  state_nxt = ST_SQ_IM;
			ST_SQ_IM:  state_nxt = ST_ENERGY;
			ST_ENERGY: state_nxt = ST_SQRT;
			ST_SQRT: begin
				if (sbit_q == 64'd1) state_nxt = stot_q ? ST_EMIT_START : ST_STORE;
			end
			ST_STORE: begin
				if (last_k) begin
					ctl.free_bank = 1'b1;
					state_nxt     = ST_TOTAL;
				end else begin
					state_nxt = ST_MAC;
				end
			end
			ST_TOTAL:      state_nxt = ST_SQRT;
			ST_EMIT_START: state_nxt = ST_RD_MAG;
			ST_RD_MAG:     state_nxt = ST_LOAD_DIV;
			ST_LOAD_DIV:   state_nxt = (den_w == '0) ? ST_OUT : ST_DIV;
			ST_DIV: if (dcnt_q == 6'(DIV_N - 1)) state_nxt = ST_OUT;
			ST_OUT: if (out_load) state_nxt = last_k ? ST_IDLE : ST_RD_MAG;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bank_q  <= job.bank;
				ch_q    <= job.ch;
				k_q     <= '0;
				total_q <= '0;
				cnt_q   <= '0;
				idx_q   <= '0;
				re_q    <= '0;
				im_q    <= '0;
				v_s1    <= 1'b0;
				v_s2    <= 1'b0;
			end
			ST_MAC: begin
				// read, multiply, accumulate pipeline over the window
				v_s1    <= issue;
				tw_c_s1 <= cos_tab[idx_q];
				tw_s_s1 <= sin_tab[idx_q];
				prod_c_s2 <= $signed(win_rdata) * tw_c_s1;
				prod_s_s2 <= $signed(win_rdata) * tw_s_s1;
				v_s2    <= v_s1;
				if (v_s2) begin
					re_q <= re_q + 64'(prod_c_s2);
					im_q <= im_q - 64'(prod_s_s2);
				end
				cnt_q <= cnt_q + 1'b1;
				if (issue) idx_q <= idx_q + LOGN'(k_q);
			end
			ST_ROUND: begin
				vr_q <= round_q8(re_q);
				vi_q <= round_q8(im_q);
			end
			ST_SQ_RE: sq_re_q <= {32'd0, vr_q} * {32'd0, vr_q};
			ST_SQ_IM: sq_im_q <= {32'd0, vi_q} * {32'd0, vi_q};
			ST_ENERGY: begin
				e_q    <= e_w;
				sv_q   <= e_w;
				sr_q   <= '0;
				sbit_q <= 64'd1 << 62;
				stot_q <= 1'b0;
			end
			ST_SQRT: begin
				// one result bit per cycle
				if (sv_q >= sr_bit) begin
					sv_q <= sv_q - sr_bit;
					sr_q <= (sr_q >> 1) + sbit_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			ST_STORE: begin
				total_q <= sat_add(total_q, e_q);
				if (k_q == HARM_W'(1)) rms1_q <= sr_q[MAG_W-1:0];
				if (!last_k) k_q <= k_q + 1'b1;
				cnt_q <= '0;
				idx_q <= '0;
				re_q  <= '0;
				im_q  <= '0;
				v_s1  <= 1'b0;
				v_s2  <= 1'b0;
			end
			ST_TOTAL: begin
				sv_q   <= total_q;
				sr_q   <= '0;
				sbit_q <= 64'd1 << 62;
				stot_q <= 1'b1;
			end
			ST_EMIT_START: begin
				tot_rms_q <= sr_q[MAG_W-1:0];
				k_q       <= '0;
			end
			ST_LOAD_DIV: begin
				mag_q  <= mag_rdata;
				num_q  <= {mag_rdata, 16'd0};
				den_q  <= den_w;
				rem_q  <= '0;
				dcnt_q <= '0;
				quo_q  <= (den_w == '0) ? '1 : '0;
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					quo_q <= {quo_q[DIV_N-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DIV_N-2:0], 1'b0};
				end
				num_q  <= num_q << 1;
				dcnt_q <= dcnt_q + 1'b1;
			end
			ST_OUT: begin
				if (out_load) begin
					loop_id          <= ch_q;
					harmonic         <= k_q;
					rms_magnitude    <= mag_q;
					content_ratio    <= (|quo_q[DIV_N-1:RATIO_W]) ? RATIO_MAX
						: quo_q[RATIO_W-1:0];
					fundamental_zero <= (rms1_q == '0);
					last             <= last_k;
					if (!last_k) k_q <= k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/harmonic_spectrum_analyzer.sv
`timescale 1ns / 1ps
// Harmonic analyzer: collects WINDOW_LEN samples per window (channel of the first sample
// tags the window; samples on channels at or above CHANNELS are dropped) and then emits
// HARMONICS results, DC first, each with Q.8 RMS magnitude and a Q.16 content ratio. A
// window whose first sample is zero produces no results. Samples go into one of two
// window banks at one beat per cycle, so filling the next window overlaps the analysis
// of the previous one; the input stalls only when both banks are waiting. The analysis
// is one multiply-accumulate pair per sample per bin, then a bit-serial square root per
// bin, and per result a bit-serial restoring divider.
module harmonic_spectrum_analyzer #(
	parameter int WINDOW_LEN = hsa_pkg::WINDOW_LEN_DEF,
	parameter int HARMONICS  = hsa_pkg::HARMONICS_DEF,
	parameter int CHANNELS   = hsa_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [hsa_pkg::CH_W-1:0]            channel,
	input  logic signed [hsa_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hsa_pkg::CH_W-1:0]            loop_id,
	output logic [hsa_pkg::HARM_W-1:0]          harmonic,
	output logic [hsa_pkg::MAG_W-1:0]           rms_magnitude,
	output logic [hsa_pkg::RATIO_W-1:0]         content_ratio,
	output logic                                fundamental_zero,
	output logic                                last
);
	import hsa_pkg::*;

	localparam int AW = $clog2(WINDOW_LEN) + 1;

	logic              win_we;
	logic [AW-1:0]     win_waddr, win_raddr;
	logic [SAMPLE_W-1:0] win_wdata, win_rdata;
	logic              job_valid;
	job_t              job;
	back_ctl_t         ctl;

	// Front: accept and classify samples
	hsa_front #(.WINDOW_LEN(WINDOW_LEN), .CHANNELS(CHANNELS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.channel  (channel),
		.sample   (sample),
		.win_we   (win_we),
		.win_waddr(win_waddr),
		.win_wdata(win_wdata),
		.job_valid(job_valid),
		.job      (job),
		.ctl      (ctl)
	);

	// Two window banks
	hsa_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 * WINDOW_LEN)) u_win_ram (
		.clk  (clk),
		.we   (win_we),
		.waddr(win_waddr),
		.wdata(win_wdata),
		.raddr(win_raddr),
		.rdata(win_rdata)
	);

	// Back: transform, magnitudes, ratios
	hsa_back #(.WINDOW_LEN(WINDOW_LEN), .HARMONICS(HARMONICS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (job_valid),
		.job             (job),
		.ctl             (ctl),
		.win_raddr       (win_raddr),
		.win_rdata       (win_rdata),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.loop_id         (loop_id),
		.harmonic        (harmonic),
		.rms_magnitude   (rms_magnitude),
		.content_ratio   (content_ratio),
		.fundamental_zero(fundamental_zero),
		.last            (last)
	);

endmodule

>>> rtl/hsa_checker.sv
`timescale 1ns / 1ps
`include "harmonic_spectrum_analyzer_assert.svh"
module hsa_checker #(
	parameter int HARMONICS = hsa_pkg::HARMONICS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [hsa_pkg::HARM_W-1:0]       harmonic,
	input logic [hsa_pkg::RATIO_W-1:0]      content_ratio,
	input logic                             fundamental_zero,
	input logic                             last
);
	import hsa_pkg::*;

	// A stalled result beat holds
	`HSA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(harmonic) && $stable(content_ratio), "result beat changed while stalled")

	// Last marks the top harmonic only
	`HSA_ASSERT_IMP(a_last_tie, clk, arst_n, out_valid, last == (harmonic == HARM_W'(HARMONICS - 1)), "last does not match harmonic order")

	// Zero fundamental saturates the AC ratios
	`HSA_ASSERT_IMP(a_fz_sat, clk, arst_n, out_valid && fundamental_zero && (harmonic != '0), content_ratio == RATIO_MAX, "ratio not saturated on zero fundamental")

	// Harmonics of a window come in order
	`HSA_ASSERT_NXT(a_order, clk, arst_n, out_valid && out_ready && !last, !out_valid || (harmonic == $past(harmonic) + 1'b1), "harmonic order skipped")

endmodule

bind harmonic_spectrum_analyzer hsa_checker #(.HARMONICS(HARMONICS)) u_hsa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.harmonic        (harmonic),
	.content_ratio   (content_ratio),
	.fundamental_zero(fundamental_zero),
	.last            (last)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import hsa_pkg::*;

	localparam int NLEN = WINDOW_LEN_DEF;
	localparam int NHARM = HARMONICS_DEF;
	localparam int NCH = CHANNELS_DEF;
	localparam logic [CH_W-1:0] CH_DROPPED = 2'd3;
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7F_FFFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = -24'sh80_0000;

	// Shapes of directed windows
	typedef enum int {W_CONST, W_ALT, W_SQUARE, W_RAMP, W_ZERO_FIRST, W_MIXED_CH} wshape_t;

	typedef struct {
		wshape_t          shape;
		logic [CH_W-1:0]  ch;
		logic signed [SAMPLE_W-1:0] amp;
	} win_row_t;

	typedef struct {
		logic [CH_W-1:0]    loop_id;
		logic [HARM_W-1:0]  harmonic;
		logic [MAG_W-1:0]   rms;
		logic [RATIO_W-1:0] ratio;
		logic               fz;
		logic               last;
	} harm_res_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [CH_W-1:0] channel, loop_id;
	logic signed [SAMPLE_W-1:0] sample;
	logic [HARM_W-1:0] harmonic;
	logic [MAG_W-1:0] rms_magnitude;
	logic [RATIO_W-1:0] content_ratio;
	logic fundamental_zero, last;

	harmonic_spectrum_analyzer uut (.*);

	// Predictor state
	longint cos_q28[NLEN];
	longint sin_q28[NLEN];
	int win_smp[NLEN];
	int fill_cnt;
	logic [CH_W-1:0] win_ch;
	harm_res_t spectrum_q[$];

	int errors, beats_in, results_seen, windows_out, windows_silent, fz_windows;
	bit calm;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Q28 cos/sin table by Taylor series
	task automatic build_twiddles();
		longint unsigned mp, q32, theta, term;
		longint c, s;
		for (int m = 0; m < NLEN; m++) begin
			mp = (2 * m <= NLEN) ? 64'(m) : 64'(NLEN - m);
			q32 = (64'h6_487E_D511 * mp + NLEN / 2) / NLEN;
			theta = (q32 + 8) >> 4;
			term = 64'd1 << 28;
			c = term;
			s = 0;
			for (int n = 1; n < 40 && term != 0; n++) begin
				term = ((term * theta + (64'd1 << 27)) >> 28) / n;
				case (n % 4)
					0: c += term;
					1: s += term;
					2: c -= term;
					default: s -= term;
				endcase
			end
			cos_q28[m] = c;
			sin_q28[m] = (2 * m > NLEN) ? -s : s;
		end
	endtask

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
		logic [64:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[64] ? 64'hFFFF_FFFF_FFFF_FFFF : t[63:0];
	endfunction

	function automatic logic [RATIO_W-1:0] q16_ratio(longint unsigned num,
		longint unsigned den);
		longint unsigned q;
		if (den == 0) return RATIO_MAX;
		q = (num << 16) / den;
		return (q > 64'hFF_FFFF) ? RATIO_MAX : q[RATIO_W-1:0];
	endfunction

	function automatic longint unsigned q8_of(longint x);
		longint unsigned a, d;
		d = 64'd1 << 27;
		a = (x < 0) ? -x : x;
		a = (a + d / 2) / d;
		return (a > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a;
	endfunction

	// Accepted beat: skip channels >= NCH, fill window, expand a full window (first sample nonzero) into results
	task automatic spectrum_accept(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp);
		longint re, im;
		longint unsigned e, total, tot_rms, rms1;
		longint unsigned mag[NHARM];
		int idx;
		harm_res_t r;
		if (ch >= NCH) return;
		if (fill_cnt == 0) win_ch = ch;
		win_smp[fill_cnt] = smp;
		fill_cnt++;
		if (fill_cnt < NLEN) return;
		fill_cnt = 0;
		if (win_smp[0] == 0) begin
			windows_silent++;
			return;
		end
		total = 0;
		for (int k = 0; k < NHARM; k++) begin
			re = 0;
			im = 0;
			idx = 0;
			for (int n = 0; n < NLEN; n++) begin
				re += longint'(win_smp[n]) * cos_q28[idx];
				im -= longint'(win_smp[n]) * sin_q28[idx];
				idx = (idx + k % NLEN) % NLEN;
			end
			e = add_sat(q8_of(re) * q8_of(re), q8_of(im) * q8_of(im));
			if (k > 0) e = add_sat(e, e);
			total = add_sat(total, e);
			e = isqrt(e);
			mag[k] = (e > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : e;
		end
		tot_rms = isqrt(total);
		rms1 = mag[1];
		if (rms1 == 0) fz_windows++;
		for (int k = 0; k < NHARM; k++) begin
			r.loop_id = win_ch;
			r.harmonic = HARM_W'(k);
			r.rms = MAG_W'(mag[k]);
			r.ratio = (k == 0) ? q16_ratio(mag[0], tot_rms) : q16_ratio(mag[k], rms1);
			r.fz = (rms1 == 0);
			r.last = (k == NHARM - 1);
			spectrum_q.push_back(r);
		end
		windows_out++;
	endtask

	// One input beat, with random gaps before it while not calm
	task automatic send_beat(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] smp);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		channel = ch;
		sample = smp;
		do @(posedge clk); while (!in_ready);
		spectrum_accept(ch, smp);
		beats_in++;
	endtask

	task automatic send_window(win_row_t w);
		logic signed [SAMPLE_W-1:0] v;
		for (int n = 0; n < NLEN; n++) begin
			case (w.shape)
				W_CONST: v = w.amp;
				W_ALT: v = n[0] ? -w.amp : w.amp;
				W_SQUARE: v = (n < NLEN / 2) ? w.amp : -w.amp;
				W_RAMP: v = SAMPLE_W'(int'(w.amp) + n * 65536);
				W_ZERO_FIRST: v = (n == 0) ? 24'sd0 : w.amp;
				default: begin
					// dropped beats woven in between the real ones
					if (n % 5 == 2) send_beat(CH_DROPPED, ~w.amp);
					v = SAMPLE_W'($urandom());
				end
			endcase
			send_beat(w.ch, v);
		end
	endtask

	task automatic drain_wait();
		@(negedge clk);
		in_valid = 1'b0;
		while (spectrum_q.size() != 0) @(negedge clk);
	endtask

	// Receiver stalls
	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);

	// Result checker
	always @(posedge clk) begin
		harm_res_t x;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (spectrum_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat harmonic=%0d", $time, harmonic);
			end else begin
				x = spectrum_q.pop_front();
				if (loop_id !== x.loop_id || harmonic !== x.harmonic ||
					rms_magnitude !== x.rms || content_ratio !== x.ratio ||
					fundamental_zero !== x.fz || last !== x.last) begin
					errors++;
					$display("%0t: mismatch exp id=%0d h=%0d rms=%h ratio=%h fz=%b last=%b",
						$time, x.loop_id, x.harmonic, x.rms, x.ratio, x.fz, x.last);
					$display("%0t:          got id=%0d h=%0d rms=%h ratio=%h fz=%b last=%b",
						$time, loop_id, harmonic, rms_magnitude, content_ratio,
						fundamental_zero, last);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#8ms;
		$display("[harmonic_spectrum_analyzer] ERROR");
		$finish;
	end

	initial begin
		win_row_t dir_rows[$];
		logic signed [SAMPLE_W-1:0] v;
		errors = 0;
		beats_in = 0;
		results_seen = 0;
		windows_out = 0;
		windows_silent = 0;
		fz_windows = 0;
		fill_cnt = 0;
		win_ch = '0;
		calm = 1'b0;
		in_valid = 1'b0;
		channel = '0;
		sample = '0;
		build_twiddles();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed window: square shape at the most negative amplitude, which negates to itself, so all samples equal SMP_MIN
		dir_rows = '{
			'{W_SQUARE, 2'd0, SMP_MIN}
		};
		foreach (dir_rows[i]) send_window(dir_rows[i]);
		drain_wait();

		// Random window, no idling on either side until half its results are out
		calm = 1'b1;
		while (windows_out + windows_silent < 2) begin
			for (int n = 0; n < NLEN; n++) begin
				case ($urandom_range(0, 3))
					0: v = SAMPLE_W'($urandom());
					1: v = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
					2: v = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
					default: v = (n % 32 < 16) ? 24'sd3000000 : -24'sd3000000;
				endcase
				if (n == 0 && $urandom_range(0, 9) == 0) v = '0;
				if ($urandom_range(0, 9) == 0)
					send_beat(CH_DROPPED, SAMPLE_W'($urandom()));
				send_beat(CH_W'($urandom_range(0, NCH - 1)), v);
			end
		end
		@(negedge clk);
		in_valid = 1'b0;
		while (spectrum_q.size() > NHARM / 2) @(negedge clk);
		calm = 1'b0;
		drain_wait();
		repeat (200) @(posedge clk);
		$display("Sent %0d beats; %0d windows analyzed (%0d with zero fundamental), %0d silent",
			beats_in, windows_out, fz_windows, windows_silent);
		$display("Checked %0d harmonic results, %0d mismatches", results_seen, errors);
		if (errors == 0 && spectrum_q.size() == 0)
			$display("[harmonic_spectrum_analyzer] OK");
		else
			$display("[harmonic_spectrum_analyzer] ERROR");
		$finish;
	end

endmodule
